// ===== rtl/core/fte_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fte_pkg : shared types and constants of the fuzzy centroid estimator
// Breakpoint tables, rule table, class codes and default formats.
// ============================================================================
package fte_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int MU_BITS_DEF   = 15;

    // Output domain sweep over whole units
    localparam int SWEEP_LO = 150;
    localparam int SWEEP_N  = 101;

    // Strength sum below 1/NO_FIRE_SCALE counts as no rule firing
    localparam int NO_FIRE_SCALE = 10000;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        CLS_GOOD    = 2'd0,
        CLS_CAUTION = 2'd1,
        CLS_DANGER  = 2'd2
    } cls_t;

    typedef enum logic [1:0] {
        MK_ZERO = 2'd0,
        MK_ONE  = 2'd1,
        MK_RISE = 2'd2,
        MK_FALL = 2'd3
    } mem_kind_t;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        logic [7:0] d;
    } brk_t;

    localparam brk_t SAT_SETS [4] = '{
        '{8'd0,  8'd0,  8'd75,  8'd80},
        '{8'd75, 8'd80, 8'd88,  8'd90},
        '{8'd85, 8'd90, 8'd94,  8'd95},
        '{8'd92, 8'd95, 8'd100, 8'd100}
    };

    localparam brk_t HR_SETS [4] = '{
        '{8'd50,  8'd50,  8'd60,  8'd70},
        '{8'd60,  8'd70,  8'd80,  8'd90},
        '{8'd80,  8'd90,  8'd100, 8'd110},
        '{8'd100, 8'd110, 8'd120, 8'd120}
    };

    localparam brk_t LVL_SETS [3] = '{
        '{8'd150, 8'd150, 8'd180, 8'd200},
        '{8'd190, 8'd200, 8'd230, 8'd240},
        '{8'd230, 8'd240, 8'd250, 8'd250}
    };

    // Row: saturation set, column: heart rate set
    localparam cls_t RULES [4][4] = '{
        '{CLS_DANGER,  CLS_DANGER,  CLS_DANGER,  CLS_DANGER},
        '{CLS_DANGER,  CLS_DANGER,  CLS_DANGER,  CLS_DANGER},
        '{CLS_CAUTION, CLS_CAUTION, CLS_DANGER,  CLS_DANGER},
        '{CLS_CAUTION, CLS_GOOD,    CLS_CAUTION, CLS_DANGER}
    };

endpackage

// ===== rtl/core/fte_div.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fte_div : restoring divider, one quotient bit per cycle
// Caller guarantees the quotient fits QUO_W bits.
// ============================================================================
module fte_div #(
    parameter int DEN_W = 13,
    parameter int QUO_W = 15
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DEN_W+QUO_W-1:0]   num,
    input  logic [DEN_W-1:0]         den,
    output logic                     busy,
    output logic                     done,
    output logic [QUO_W-1:0]         quo
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [DEN_W+QUO_W-1:0] acc_reg, acc_next;
    logic [DEN_W-1:0]       den_reg;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [DEN_W+1:0]       trial;
    logic [DEN_W-1:0]       rem_new;

    always_comb
    begin
        trial   = {1'b0, acc_reg[DEN_W+QUO_W-1:QUO_W], acc_reg[QUO_W-1]} - {2'b00, den_reg};
        rem_new = trial[DEN_W+1] ? {acc_reg[DEN_W+QUO_W-2:QUO_W], acc_reg[QUO_W-1]}
                                 : trial[DEN_W-1:0];
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = num;
            cnt_next  = CNT_W'(QUO_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = {rem_new, acc_reg[QUO_W-2:0], ~trial[DEN_W+1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = acc_reg[QUO_W-1:0];

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");

endmodule

// ===== rtl/core/fte_member.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fte_member : trapezoid region classifier
// Give flat membership directly, or the dividend and divisor of an edge.
// ============================================================================
module fte_member #(
    parameter int FRAC_BITS = 8,
    parameter int MU_BITS   = 15
) (
    input  logic [((FRAC_BITS + 8 > 16) ? FRAC_BITS + 8 : 16)-1:0] x,
    input  fte_pkg::brk_t                                          set,
    output fte_pkg::mem_kind_t                                     kind,
    output logic [FRAC_BITS+5+MU_BITS-1:0]                         num,
    output logic [FRAC_BITS+5-1:0]                                 den
);
    import fte_pkg::*;

    localparam int XW = (FRAC_BITS + 8 > 16) ? FRAC_BITS + 8 : 16;

    logic [XW-1:0] pa, pb, pc, pd;
    logic [XW-1:0] diff_r, diff_f;
    logic [7:0]    span_r, span_f;

    always_comb
    begin
        pa     = XW'({set.a, {FRAC_BITS{1'b0}}});
        pb     = XW'({set.b, {FRAC_BITS{1'b0}}});
        pc     = XW'({set.c, {FRAC_BITS{1'b0}}});
        pd     = XW'({set.d, {FRAC_BITS{1'b0}}});
        diff_r = x - pa;
        diff_f = pd - x;
        span_r = set.b - set.a;
        span_f = set.d - set.c;
        num    = {diff_r[FRAC_BITS+4:0], {MU_BITS{1'b0}}};
        den    = {span_r[4:0], {FRAC_BITS{1'b0}}};
        if (x <= pa)
        begin
            kind = (set.a == set.b) ? MK_ONE : MK_ZERO;
        end
        else if (x >= pd)
        begin
            kind = (set.c == set.d) ? MK_ONE : MK_ZERO;
        end
        else if (x >= pb && x <= pc)
        begin
            kind = MK_ONE;
        end
        else if (x < pb)
        begin
            kind = MK_RISE;
        end
        else
        begin
            kind = MK_FALL;
            num  = {diff_f[FRAC_BITS+4:0], {MU_BITS{1'b0}}};
            den  = {span_f[4:0], {FRAC_BITS{1'b0}}};
        end
    end

endmodule

// ===== rtl/core/fte_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fte_front : input fuzzification and rule evaluation
// Take one word, build eight memberships, fold 16 rules into three strengths.
// ============================================================================
module fte_front #(
    parameter int FRAC_BITS = fte_pkg::FRAC_BITS_DEF,
    parameter int MU_BITS   = fte_pkg::MU_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [15:0]                saturation,
    input  logic [15:0]                heart_rate,
    input  logic                       q_full,
    output logic                       q_push,
    output logic [3*(MU_BITS+1)-1:0]   q_data
);
    import fte_pkg::*;

    localparam int XW  = (FRAC_BITS + 8 > 16) ? FRAC_BITS + 8 : 16;
    localparam int DW  = FRAC_BITS + 5;
    localparam int MUW = MU_BITS + 1;

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_EVAL = 5'b00010,
        F_DIV  = 5'b00100,
        F_RULE = 5'b01000,
        F_PUSH = 5'b10000
    } front_state_t;

    front_state_t    state_reg, state_next;
    logic [2:0]      idx_reg, idx_next;
    logic [15:0]     sat_reg, hr_reg;
    logic [MUW-1:0]  mus_reg [4];
    logic [MUW-1:0]  muh_reg [4];
    logic [MUW-1:0]  str_reg [3];
    logic [MUW-1:0]  str_next [3];
    logic [MUW-1:0]  str_row [3];

    logic [XW-1:0]          x_sel;
    brk_t                   set_sel;
    mem_kind_t              kind;
    logic [DW+MU_BITS-1:0]  div_num;
    logic [DW-1:0]          div_den;
    logic                   div_start, div_busy, div_done;
    logic [MU_BITS-1:0]     div_quo;
    logic                   mu_we, adv;
    logic [MUW-1:0]         mu_wdata;

    always_comb
    begin
        x_sel   = idx_reg[2] ? XW'(hr_reg) : XW'(sat_reg);
        set_sel = idx_reg[2] ? HR_SETS[idx_reg[1:0]] : SAT_SETS[idx_reg[1:0]];
    end

    fte_member #(
        .FRAC_BITS (FRAC_BITS),
        .MU_BITS   (MU_BITS)
    ) u_member (
        .x    (x_sel),
        .set  (set_sel),
        .kind (kind),
        .num  (div_num),
        .den  (div_den)
    );

    fte_div #(
        .DEN_W (DW),
        .QUO_W (MU_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    // One saturation row of the rule table per cycle
    always_comb
    begin
        logic [MUW-1:0] row_mu;
        logic [MUW-1:0] s;
        logic [MUW-1:0] acc;
        row_mu = mus_reg[idx_reg[1:0]];
        for (int c = 0; c < 3; c++)
        begin
            acc = str_reg[c];
            for (int j = 0; j < 4; j++)
            begin
                s = (row_mu < muh_reg[j]) ? row_mu : muh_reg[j];
                if (RULES[idx_reg[1:0]][j] == cls_t'(c) && s > acc)
                begin
                    acc = s;
                end
            end
            str_row[c] = acc;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        str_next   = str_reg;
        div_start  = 1'b0;
        mu_we      = 1'b0;
        mu_wdata   = '0;
        adv        = 1'b0;
        q_push     = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = F_EVAL;
                    idx_next   = '0;
                end
            end
            F_EVAL:
            begin
                if (kind == MK_RISE || kind == MK_FALL)
                begin
                    div_start  = 1'b1;
                    state_next = F_DIV;
                end
                else
                begin
                    mu_we    = 1'b1;
                    mu_wdata = (kind == MK_ONE) ? {1'b1, {MU_BITS{1'b0}}} : '0;
                    adv      = 1'b1;
                end
            end
            F_DIV:
            begin
                if (div_done)
                begin
                    mu_we    = 1'b1;
                    mu_wdata = {1'b0, div_quo};
                    adv      = 1'b1;
                end
            end
            F_RULE:
            begin
                str_next = str_row;
                if (idx_reg == 3'd3)
                begin
                    state_next = F_PUSH;
                end
                else
                begin
                    idx_next = idx_reg + 3'd1;
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
        // advance to the next set, or on to the rules after the last one
        if (adv)
        begin
            if (idx_reg == 3'd7)
            begin
                state_next = F_RULE;
                idx_next   = '0;
                for (int c = 0; c < 3; c++)
                begin
                    str_next[c] = '0;
                end
            end
            else
            begin
                state_next = F_EVAL;
                idx_next   = idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && in_valid)
        begin
            sat_reg <= saturation;
            hr_reg  <= heart_rate;
        end
        if (mu_we)
        begin
            if (idx_reg[2])
            begin
                muh_reg[idx_reg[1:0]] <= mu_wdata;
            end
            else
            begin
                mus_reg[idx_reg[1:0]] <= mu_wdata;
            end
        end
        str_reg <= str_next;
    end

    assign in_stall = (state_reg != F_IDLE);
    assign q_data   = {str_reg[2], str_reg[1], str_reg[0]};

    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_DIV) |-> (div_busy || div_done))
        else $error("front waits on an idle divider");

endmodule

// ===== rtl/core/fte_queue.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fte_queue : short strength queue between front and back
// Hold up to QUEUE_DEPTH strength triples.
// ============================================================================
module fte_queue #(
    parameter int W = 48
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         empty
);
    import fte_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]     slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_data;
        end
    end

    assign full     = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = slot_reg[rd_reg];

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

endmodule

// ===== rtl/core/fte_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fte_back : aggregation sweep, centroid divide and class pick
// Sweep the clipped output sets, divide, then rate the centroid; if no rule fires, give zero and good.
// ============================================================================
module fte_back #(
    parameter int FRAC_BITS = fte_pkg::FRAC_BITS_DEF,
    parameter int MU_BITS   = fte_pkg::MU_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_empty,
    output logic                      q_pop,
    input  logic [3*(MU_BITS+1)-1:0]  q_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [15:0]               estimate,
    output logic [1:0]                level_class
);
    import fte_pkg::*;

    localparam int XW     = (FRAC_BITS + 8 > 16) ? FRAC_BITS + 8 : 16;
    localparam int DW     = FRAC_BITS + 5;
    localparam int MUW    = MU_BITS + 1;
    localparam int CW     = FRAC_BITS + 8;
    localparam int SUM_W  = MU_BITS + 8;
    localparam int NUM_W  = MU_BITS + 16;
    localparam int PT_W   = $clog2(SWEEP_N);
    localparam int DEN_MIN = ((1 << MU_BITS) + NO_FIRE_SCALE - 1) / NO_FIRE_SCALE;

    typedef enum logic [7:0] {
        B_IDLE  = 8'b00000001,
        B_SWEEP = 8'b00000010,
        B_CHECK = 8'b00000100,
        B_DIV   = 8'b00001000,
        B_EVAL  = 8'b00010000,
        B_MDIV  = 8'b00100000,
        B_CLS   = 8'b01000000,
        B_OUT   = 8'b10000000
    } back_state_t;

    back_state_t      state_reg, state_next;
    logic [PT_W-1:0]  pt_reg;
    logic [1:0]       idx_reg;
    logic [MUW-1:0]   str_reg [3];
    logic [NUM_W-1:0] num_reg;
    logic [SUM_W-1:0] den_reg;
    logic [CW-1:0]    crisp_reg;
    logic [MUW-1:0]   mlv_reg [3];
    logic [15:0]      est_reg;
    cls_t             cls_reg;

    logic [MUW-1:0]   lvl_tab [3][SWEEP_N];
    logic [MUW-1:0]   m_pt;
    logic [7:0]       x_pt;

    // Output-set membership at each whole point of the domain
    for (genvar k = 0; k < 3; k++)
    begin : g_set
        for (genvar g = 0; g < SWEEP_N; g++)
        begin : g_pt
            localparam int P   = SWEEP_LO + g;
            localparam int A   = int'(LVL_SETS[k].a);
            localparam int B   = int'(LVL_SETS[k].b);
            localparam int C   = int'(LVL_SETS[k].c);
            localparam int D   = int'(LVL_SETS[k].d);
            localparam int ONE = 1 << MU_BITS;
            localparam int RS  = (B > A) ? B - A : 1;
            localparam int FS  = (D > C) ? D - C : 1;
            localparam int V   = (P <= A) ? ((A == B) ? ONE : 0) :
                                 (P >= D) ? ((C == D) ? ONE : 0) :
                                 (P >= B && P <= C) ? ONE :
                                 (P < B) ? ((P - A) << MU_BITS) / RS :
                                           ((D - P) << MU_BITS) / FS;
            assign lvl_tab[k][g] = MUW'(V);
        end
    end

    always_comb
    begin
        logic [MUW-1:0] c0, c1, c2;
        c0   = (str_reg[0] < lvl_tab[0][pt_reg]) ? str_reg[0] : lvl_tab[0][pt_reg];
        c1   = (str_reg[1] < lvl_tab[1][pt_reg]) ? str_reg[1] : lvl_tab[1][pt_reg];
        c2   = (str_reg[2] < lvl_tab[2][pt_reg]) ? str_reg[2] : lvl_tab[2][pt_reg];
        m_pt = (c0 > c1) ? c0 : c1;
        m_pt = (m_pt > c2) ? m_pt : c2;
        x_pt = 8'(SWEEP_LO) + 8'(pt_reg);
    end

    // Centroid divider
    logic             cdiv_start, cdiv_busy, cdiv_done;
    logic [CW-1:0]    cdiv_quo;

    fte_div #(
        .DEN_W (SUM_W),
        .QUO_W (CW)
    ) u_cdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cdiv_start),
        .num   ({num_reg, {FRAC_BITS{1'b0}}}),
        .den   (den_reg),
        .busy  (cdiv_busy),
        .done  (cdiv_done),
        .quo   (cdiv_quo)
    );

    // Membership of the centroid in each output set
    mem_kind_t              kind;
    logic [DW+MU_BITS-1:0]  mdiv_num;
    logic [DW-1:0]          mdiv_den;
    logic                   mdiv_start, mdiv_busy, mdiv_done;
    logic [MU_BITS-1:0]     mdiv_quo;
    logic                   mu_we, adv;
    logic [MUW-1:0]         mu_wdata;

    fte_member #(
        .FRAC_BITS (FRAC_BITS),
        .MU_BITS   (MU_BITS)
    ) u_member (
        .x    (XW'(crisp_reg)),
        .set  (LVL_SETS[idx_reg]),
        .kind (kind),
        .num  (mdiv_num),
        .den  (mdiv_den)
    );

    fte_div #(
        .DEN_W (DW),
        .QUO_W (MU_BITS)
    ) u_mdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mdiv_start),
        .num   (mdiv_num),
        .den   (mdiv_den),
        .busy  (mdiv_busy),
        .done  (mdiv_done),
        .quo   (mdiv_quo)
    );

    logic no_fire;
    assign no_fire = (den_reg < SUM_W'(DEN_MIN));

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        cdiv_start = 1'b0;
        mdiv_start = 1'b0;
        mu_we      = 1'b0;
        mu_wdata   = '0;
        adv        = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = B_SWEEP;
                end
            end
            B_SWEEP:
            begin
                if (pt_reg == PT_W'(SWEEP_N - 1))
                begin
                    state_next = B_CHECK;
                end
            end
            B_CHECK:
            begin
                if (no_fire)
                begin
                    state_next = B_OUT;
                end
                else
                begin
                    cdiv_start = 1'b1;
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                if (cdiv_done)
                begin
                    state_next = B_EVAL;
                end
            end
            B_EVAL:
            begin
                if (kind == MK_RISE || kind == MK_FALL)
                begin
                    mdiv_start = 1'b1;
                    state_next = B_MDIV;
                end
                else
                begin
                    mu_we    = 1'b1;
                    mu_wdata = (kind == MK_ONE) ? {1'b1, {MU_BITS{1'b0}}} : '0;
                    adv      = 1'b1;
                end
            end
            B_MDIV:
            begin
                if (mdiv_done)
                begin
                    mu_we    = 1'b1;
                    mu_wdata = {1'b0, mdiv_quo};
                    adv      = 1'b1;
                end
            end
            B_CLS:
            begin
                state_next = B_OUT;
            end
            B_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
        if (adv)
        begin
            state_next = (idx_reg == 2'd2) ? B_CLS : B_EVAL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            pt_reg    <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
            begin
                pt_reg <= '0;
            end
            else if (state_reg == B_SWEEP && pt_reg != PT_W'(SWEEP_N - 1))
            begin
                pt_reg <= pt_reg + 1'b1;
            end
            if (cdiv_done)
            begin
                idx_reg <= '0;
            end
            else if (adv && idx_reg != 2'd2)
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            str_reg[0] <= q_data[MUW-1:0];
            str_reg[1] <= q_data[2*MUW-1:MUW];
            str_reg[2] <= q_data[3*MUW-1:2*MUW];
            num_reg    <= '0;
            den_reg    <= '0;
        end
        else if (state_reg == B_SWEEP)
        begin
            num_reg <= num_reg + NUM_W'(x_pt) * NUM_W'(m_pt);
            den_reg <= den_reg + SUM_W'(m_pt);
        end
        if (cdiv_done)
        begin
            crisp_reg <= cdiv_quo;
        end
        if (mu_we)
        begin
            mlv_reg[idx_reg] <= mu_wdata;
        end
        if (state_reg == B_CHECK && no_fire)
        begin
            est_reg <= '0;
            cls_reg <= CLS_GOOD;
        end
        else if (state_reg == B_CLS)
        begin
            est_reg <= (crisp_reg > CW'(16'hFFFF)) ? 16'hFFFF : 16'(crisp_reg);
            if (mlv_reg[2] >= mlv_reg[1] && mlv_reg[2] >= mlv_reg[0])
            begin
                cls_reg <= CLS_DANGER;
            end
            else if (mlv_reg[1] >= mlv_reg[0])
            begin
                cls_reg <= CLS_CAUTION;
            end
            else
            begin
                cls_reg <= CLS_GOOD;
            end
        end
    end

    assign out_valid   = (state_reg == B_OUT);
    assign estimate    = est_reg;
    assign level_class = cls_reg;

    a_zero_is_good: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && estimate == 16'd0) |-> (level_class == CLS_GOOD))
        else $error("zero estimate with a class other than good");

    a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_SWEEP) |-> (pt_reg <= PT_W'(SWEEP_N - 1)))
        else $error("sweep point out of range");

    a_cdiv_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DIV) |-> (cdiv_busy || cdiv_done))
        else $error("centroid wait on an idle divider");

    a_mdiv_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_MDIV) |-> (mdiv_busy || mdiv_done))
        else $error("class wait on an idle divider");

endmodule

// ===== rtl/core/fuzzy_two_input_centroid_estimator_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fuzzy_two_input_centroid_estimator_top : two-input fuzzy level estimator
// Fuzzify saturation and heart rate, infer three level strengths, defuzzify
// by centroid over 150..250 and rate the centroid as good, caution or danger.
// ============================================================================
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  in      | in_valid / in_stall  | saturation[15:0], heart_rate[15:0]
//  out     | out_valid / out_stall| estimate[15:0], level_class[1:0]
//
// The front builds the memberships of each word, one divider pass per sloped
//   edge, then evaluates the rules and pushes. The back sweeps the output
//   domain, divides for the centroid and once more for each sloped class
//   membership; the back's sweep and divides set the sustained rate.
// Reset: rst_n clears all control state at once; no clearing pass.
// Stalls: a two-word queue parts front and back, so the front takes a new
//   word while the back works or waits on out_stall, until the queue fills.
// ============================================================================
module fuzzy_two_input_centroid_estimator_top #(
    parameter int FRAC_BITS = fte_pkg::FRAC_BITS_DEF,
    parameter int MU_BITS   = fte_pkg::MU_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] saturation,
    input  logic [15:0] heart_rate,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] estimate,
    output logic [1:0]  level_class
);
    import fte_pkg::*;

    localparam int QW = 3 * (MU_BITS + 1);

    logic          q_push, q_full, q_pop, q_empty;
    logic [QW-1:0] q_wdata, q_rdata;

    // Front: accept a word and reduce it to three class strengths
    fte_front #(
        .FRAC_BITS (FRAC_BITS),
        .MU_BITS   (MU_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .saturation (saturation),
        .heart_rate (heart_rate),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_wdata)
    );

    // Hold strengths until the back is free
    fte_queue #(
        .W (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    // Back: aggregate, divide, classify and present the result word
    fte_back #(
        .FRAC_BITS (FRAC_BITS),
        .MU_BITS   (MU_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .q_data      (q_rdata),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .estimate    (estimate),
        .level_class (level_class)
    );

endmodule
